FILE: rtl/rac_pkg.sv
// Shared types and constants for the radio airtime calculator.
// Used by rac_front, rac_queue, rac_back and radio_airtime_calc.
`default_nettype none

package rac_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SF  = 3'd0,
		REG_BW  = 3'd1,
		REG_CR  = 3'd2,
		REG_PRE = 3'd3,
		REG_CRC = 3'd4
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Register reset values, also used when a write carries an illegal code.
	localparam logic [3:0] SF_DEFAULT  = 4'd7;
	localparam logic [1:0] BW_DEFAULT  = 2'd1;
	localparam logic [3:0] CR_DEFAULT  = 4'd5;
	localparam logic [7:0] PRE_DEFAULT = 8'd8;
	localparam logic       CRC_DEFAULT = 1'b1;

	// Symbol time is 2^exp us; low rate optimization starts at 2^14 us.
	localparam logic [4:0] LDRO_EXP = 5'd14;

	// ceil(x / 1000) is floor((x + 999) * RECIP_M / 2^RECIP_SHIFT), exact for x < 2^26.
	localparam int unsigned Y_W         = 26;
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned PROD_W      = Y_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_M   = 27'd68719477;
	localparam logic [Y_W-1:0]     CEIL_BIAS = 26'd999;
	localparam logic [9:0]         CAD_MARGIN = 10'd5;

	// Preamble overhead: 4.25 symbols plus 8 header symbols, in quarter symbols.
	localparam logic [11:0] FIXED_QSYM = 12'd49;

	// One classified word passed from the front to the back.
	typedef struct packed {
		logic [9:0]  dividend;   // ceil numerator, already biased by divisor - 1
		logic [3:0]  divisor;    // SF, or SF - 2 with low rate optimization
		logic [3:0]  cr;
		logic [7:0]  preamble;
		logic [4:0]  sym_exp;    // symbol time is 2^sym_exp us
		logic        ldro;
		logic [17:0] cad2_us;    // twice the detection time in us
	} rac_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_LOAD_TOT,
		BK_LOAD_CAD,
		BK_LOAD_FOUR,
		BK_TAKE_CAD,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

FILE: rtl/radio_airtime_calc.sv
// Top level of the chirp spread spectrum time-on-air calculator.
// Depends on rac_pkg, rac_front, rac_queue and rac_back.
//
// For each payload length word the block returns the symbol time, the low data
// rate optimization flag, the packet time on air (explicit header, rounded up to
// whole milliseconds), the activity detection timeout and the detection step, all
// from the spreading factor, bandwidth, coding rate, preamble and CRC registers.
// Illegal spreading factor, bandwidth or coding rate writes store the reset value.
// The input is taken whenever the two-word queue has room, so up to three words
// can be in flight besides a result waiting on the output. The back end takes
// one word at a time through the five-bit-per-cycle block count divider, then
// through the states that feed the shared reciprocal multiplier that turns the
// total, detection and four-symbol times into milliseconds, then loads the
// result register once the output is free, and only then takes the next word.
`default_nettype none

module radio_airtime_calc (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rac_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     payload_len,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [15:0]                         airtime_ms,
	output logic [16:0]                         symbol_us,
	output logic                                low_rate_opt,
	output logic [9:0]                          cad_timeout_ms,
	output logic [9:0]                          cad_step_ms
);
	import rac_pkg::*;

	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	rac_item_t push_item;
	rac_item_t q_head;

	rac_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.payload_len (payload_len),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	rac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	rac_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.airtime_ms     (airtime_ms),
		.symbol_us      (symbol_us),
		.low_rate_opt   (low_rate_opt),
		.cad_timeout_ms (cad_timeout_ms),
		.cad_step_ms    (cad_step_ms)
	);

endmodule

`default_nettype wire

FILE: rtl/rac_front.sv
// Front end: configuration registers and classification of each payload word.
// Depends on rac_pkg; feeds rac_queue.
`default_nettype none

module rac_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rac_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  payload_len,
	input  wire logic                        q_full,
	output logic                             push,
	output rac_pkg::rac_item_t               push_item
);
	import rac_pkg::*;

	logic [3:0] sf_q;
	logic [1:0] bw_q;
	logic [3:0] cr_q;
	logic [7:0] pre_q;
	logic       crc_q;

	logic [4:0]  sym_exp;
	logic        ldro;
	logic [3:0]  divisor;
	logic [10:0] pos_part;
	logic [10:0] dividend_w;
	logic [12:0] cad_base;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q  <= SF_DEFAULT;
			bw_q  <= BW_DEFAULT;
			cr_q  <= CR_DEFAULT;
			pre_q <= PRE_DEFAULT;
			crc_q <= CRC_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SF: begin
					sf_q <= (cfg_data[3:0] inside {[4'd6:4'd12]}) ? cfg_data[3:0] : SF_DEFAULT;
				end
				REG_BW: begin
					bw_q <= (cfg_data[1:0] == 2'd3) ? BW_DEFAULT : cfg_data[1:0];
				end
				REG_CR: begin
					cr_q <= (cfg_data[3:0] inside {[4'd5:4'd8]}) ? cfg_data[3:0] : CR_DEFAULT;
				end
				REG_PRE: begin
					pre_q <= cfg_data;
				end
				REG_CRC: begin
					crc_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// The bandwidth is 62.5 kHz times 2^bw, so the symbol time is 2^(SF + 4 - bw) us.
	always_comb begin
		sym_exp  = 5'({1'b0, sf_q} + 5'd4 - {3'b0, bw_q});
		ldro     = (sym_exp >= LDRO_EXP);
		divisor  = ldro ? (sf_q - 4'd2) : sf_q;
		// The bit count numerator is always a multiple of four; this is its part without the SF term, divided by four.
		pos_part = {2'b0, payload_len, 1'b0} + 11'd7 + (crc_q ? 11'd4 : 11'd0);
		if (pos_part > {7'b0, sf_q}) begin
			dividend_w = pos_part - {7'b0, sf_q} + {7'b0, divisor} - 11'd1;
		end else begin
			dividend_w = '0;
		end
		cad_base = (13'd1 << sf_q) + 13'd32;
	end

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.dividend = dividend_w[9:0];
		push_item.divisor  = divisor;
		push_item.cr       = cr_q;
		push_item.preamble = pre_q;
		push_item.sym_exp  = sym_exp;
		push_item.ldro     = ldro;
		push_item.cad2_us  = {5'b0, cad_base} << (3'd5 - {1'b0, bw_q});
	end

endmodule

`default_nettype wire

FILE: rtl/rac_queue.sv
// Two-entry queue of classified words between the front and the back.
// Depends on rac_pkg for the word type.
`default_nettype none

module rac_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rac_pkg::rac_item_t push_item,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output rac_pkg::rac_item_t head
);
	import rac_pkg::*;

	rac_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rac_back.sv
// Back end: block count division, time sums and the shared divide-by-1000 unit.
// Depends on rac_pkg; takes words from rac_queue and drives the result register.
`default_nettype none

module rac_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire rac_pkg::rac_item_t q_head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [15:0]        airtime_ms,
	output logic [16:0]        symbol_us,
	output logic               low_rate_opt,
	output logic [9:0]         cad_timeout_ms,
	output logic [9:0]         cad_step_ms
);
	import rac_pkg::*;

	back_state_t state_q, state_d;
	logic        out_load;
	logic        out_free;

	rac_item_t   item_q;
	logic [9:0]  dvd_q;
	logic [9:0]  quot_q;
	logic [3:0]  rem_q;
	logic        div_cnt_q;
	logic [4:0]  qbits;
	logic [3:0]  rem_d;

	logic [Y_W-1:0]    y_q;
	logic [PROD_W-1:0] prod_q;
	logic [QUOT_W-1:0] quot_ms;
	logic [15:0]       air_q;
	logic [9:0]        cadto_q;

	logic [10:0]    blk_cr;
	logic [11:0]    qsym;
	logic [Y_W-1:0] total_us;
	logic [Y_W-1:0] four_us;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_cnt_q) begin
					state_d = BK_LOAD_TOT;
				end
			end
			BK_LOAD_TOT:  state_d = BK_LOAD_CAD;
			BK_LOAD_CAD:  state_d = BK_LOAD_FOUR;
			BK_LOAD_FOUR: state_d = BK_TAKE_CAD;
			BK_TAKE_CAD:  state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!q_empty) begin
						pop     = 1'b1;
						state_d = BK_DIV;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Five restoring division steps per cycle; the remainder stays below the divisor.
	always_comb begin
		logic [4:0] r;
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < 5; i++) begin
			r = {r[3:0], dvd_q[9-i]};
			if (r >= {1'b0, item_q.divisor}) begin
				r           = r - {1'b0, item_q.divisor};
				qbits[4-i] = 1'b1;
			end
		end
		rem_d = r[3:0];
	end

	// Total time in quarter symbols, then scaled by the quarter symbol time.
	always_comb begin
		blk_cr   = {4'b0, quot_q[6:0]} * {7'b0, item_q.cr};
		qsym     = {2'b0, item_q.preamble, 2'b0} + FIXED_QSYM + {blk_cr[9:0], 2'b0};
		total_us = {14'b0, qsym} << (item_q.sym_exp - 5'd2);
		four_us  = 26'(1) << (item_q.sym_exp + 5'd2);
	end

	assign quot_ms = prod_q[PROD_W-1:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= 1'b0;
		end else if (pop) begin
			div_cnt_q <= 1'b0;
		end else if (state_q == BK_DIV) begin
			div_cnt_q <= ~div_cnt_q;
		end
	end

	// The reciprocal multiplier runs every cycle on whatever operand is loaded.
	always_ff @(posedge clk) begin
		prod_q <= {{RECIP_W{1'b0}}, y_q} * {{Y_W{1'b0}}, RECIP_M};
		if (pop) begin
			item_q <= q_head;
			dvd_q  <= q_head.dividend;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (state_q == BK_DIV) begin
			dvd_q  <= {dvd_q[4:0], 5'b0};
			rem_q  <= rem_d;
			quot_q <= {quot_q[4:0], qbits};
		end
		case (state_q)
			BK_LOAD_TOT:  y_q <= total_us + CEIL_BIAS;
			BK_LOAD_CAD:  y_q <= {8'b0, item_q.cad2_us} + CEIL_BIAS;
			BK_LOAD_FOUR: begin
				y_q   <= four_us + CEIL_BIAS;
				air_q <= quot_ms[15:0];
			end
			BK_TAKE_CAD:  cadto_q <= quot_ms[9:0] + CAD_MARGIN;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			airtime_ms     <= air_q;
			symbol_us      <= 17'd1 << item_q.sym_exp;
			low_rate_opt   <= item_q.ldro;
			cad_timeout_ms <= cadto_q;
			cad_step_ms    <= (cadto_q > quot_ms[9:0]) ? cadto_q : quot_ms[9:0];
		end
	end

endmodule

`default_nettype wire
